@@ rtl/ray_box_pick_closest_assert.svh @@
// assertion macros for the ray box picker
`ifndef RAY_BOX_PICK_CLOSEST_ASSERT_SVH
`define RAY_BOX_PICK_CLOSEST_ASSERT_SVH

// same-cycle implication
`define RBPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RBPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rbpc_pkg.sv @@
package rbpc_pkg;

  localparam int MAX_BOXES_DEF = 256;
  localparam int FRAC_BITS_DEF = 16;

  localparam int POS_W   = 32;
  localparam int DIR_W   = 18;
  localparam int SCALE_W = 20;
  localparam int DIST_W  = 31;
  localparam int IDX_W   = 8;
  localparam int REG_W   = 3;

  typedef logic [REG_W-1:0] reg_index_t;

  localparam reg_index_t REG_ORIGIN_X = 3'd0;
  localparam reg_index_t REG_ORIGIN_Y = 3'd1;
  localparam reg_index_t REG_ORIGIN_Z = 3'd2;
  localparam reg_index_t REG_DIR_X    = 3'd3;
  localparam reg_index_t REG_DIR_Y    = 3'd4;
  localparam reg_index_t REG_DIR_Z    = 3'd5;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

endpackage

@@ rtl/ray_box_pick_closest.sv @@
// ray pick against axis-aligned boxes, closest hit of a sweep
// cfg_we/cfg_index/cfg_data set the ray origin (0..2) and direction (3..5);
// write them only while the block is idle
// s_* takes one box per transfer: centre, full size, tlast marks the last
// box of a sweep. m_* gives one result per box: hit flag, distance, and the
// nearest hit of the sweep so far; m_tlast closes the sweep and the tracker
// and box counter clear behind it
// each box runs six slab divisions through one bit-serial restoring divider,
// one quotient bit per cycle; a division loads the operands in the setup
// step, shifts out NW = 33 + FRAC_BITS quotient bits and then folds the
// quotient into the slab interval; an axis with zero direction checks the
// origin against the slab instead of a division pair
// one box is in work at a time, s_tready is high only when the divider
// sequencer is idle
// a result waits in the output register while m_tready is low; the next box
// may be taken and worked on meanwhile, and it stalls only at its final step
// reset clears the ray to origin 0, direction +z, and clears the tracker
`include "ray_box_pick_closest_assert.svh"

module ray_box_pick_closest import rbpc_pkg::*; #(
  parameter int MAX_BOXES = MAX_BOXES_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [REG_W-1:0]   cfg_index,
  input  logic [POS_W-1:0]   cfg_data,
  input  logic               s_tvalid,
  output logic               s_tready,
  // center_x, center_y, center_z, scale_x, scale_y, scale_z, zero pad
  input  logic [159:0]       s_tdata,
  input  logic               s_tlast,
  output logic               m_tvalid,
  input  logic               m_tready,
  // hit, hit_distance, closest_found, closest_index, zero pad
  output logic [47:0]        m_tdata,
  output logic               m_tlast
);

  localparam int MW   = 34;
  localparam int NW   = MW + FRAC_BITS - 1;
  localparam int TW   = NW + 2;
  localparam int CNTW = $clog2(NW + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_NEXT  = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  localparam logic signed [TW-1:0] T_NEG_INF = {1'b1, {(TW-1){1'b0}}};
  localparam logic signed [TW-1:0] T_POS_INF = {1'b0, {(TW-1){1'b1}}};
  localparam logic signed [TW-1:0] T_DMAX    = {{(TW-DIST_W){1'b0}}, DIST_MAX};

  logic [2:0] state;

  logic signed [POS_W-1:0] org [3];
  logic signed [DIR_W-1:0] dir [3];

  logic signed [POS_W-1:0] ctr [3];
  logic [SCALE_W-1:0]      scl [3];
  logic                    last_q;

  logic [1:0] axis;
  logic       upper;
  logic       miss;
  logic signed [TW-1:0] near_t, far_t, t_first;

  logic [NW-1:0]    num_sh, quo;
  logic [DIR_W-1:0] rem, den;
  logic             qneg;
  logic [CNTW-1:0]  cnt;

  logic [DIST_W-1:0] best_dist;
  logic [IDX_W-1:0]  best_idx, box_cnt;
  logic              best_valid;

  // slab bound minus origin, both doubled
  logic signed [34:0] c2, s2, o2, bound2;
  logic signed [35:0] diff, diff_abs;
  logic               diff_neg;
  logic [MW-1:0]      diff_mag;
  logic signed [DIR_W-1:0] dval;
  logic               dz;
  logic [DIR_W-1:0]   dmag;

  always_comb begin
    c2       = {{2{ctr[axis][POS_W-1]}}, ctr[axis], 1'b0};
    s2       = {15'b0, scl[axis]};
    o2       = {{2{org[axis][POS_W-1]}}, org[axis], 1'b0};
    bound2   = upper ? c2 + s2 : c2 - s2;
    diff     = {bound2[34], bound2} - {o2[34], o2};
    diff_neg = diff[35];
    diff_abs = diff_neg ? -diff : diff;
    diff_mag = diff_abs[MW-1:0];
    dval     = dir[axis];
    dz       = (dval == '0);
    dmag     = dval[DIR_W-1] ? DIR_W'(-dval) : DIR_W'(dval);
  end

  // one restoring step
  logic [DIR_W:0] trial;
  logic           ge;
  always_comb begin
    trial = {rem, num_sh[NW-1]};
    ge    = (trial >= {1'b0, den});
  end

  logic signed [TW-1:0] tq, tmn, tmx;
  always_comb begin
    tq  = qneg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
    tmn = (t_first < tq) ? t_first : tq;
    tmx = (t_first < tq) ? tq : t_first;
  end

  // final decision
  logic                 hit, upd, fin_fire;
  logic signed [TW-1:0] tsel;
  logic [DIST_W-1:0]    hit_len;
  logic [8:0]           cnt_inc;
  always_comb begin
    hit  = !miss && !far_t[TW-1] && !(near_t > far_t);
    tsel = (!near_t[TW-1] && near_t != '0) ? near_t : far_t;
    if (!hit || tsel[TW-1]) hit_len = '0;
    else if (tsel > T_DMAX) hit_len = DIST_MAX;
    else                    hit_len = tsel[DIST_W-1:0];
    upd      = hit && (!best_valid || hit_len < best_dist);
    fin_fire = (state == ST_FIN) && (!m_tvalid || m_tready);
    cnt_inc  = {1'b0, box_cnt} + 9'd1;
  end

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      org[0] <= '0;
      org[1] <= '0;
      org[2] <= '0;
      dir[0] <= '0;
      dir[1] <= '0;
      dir[2] <= DIR_W'(65536);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN_X: org[0] <= cfg_data;
        REG_ORIGIN_Y: org[1] <= cfg_data;
        REG_ORIGIN_Z: org[2] <= cfg_data;
        REG_DIR_X:    dir[0] <= cfg_data[DIR_W-1:0];
        REG_DIR_Y:    dir[1] <= cfg_data[DIR_W-1:0];
        REG_DIR_Z:    dir[2] <= cfg_data[DIR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      ctr[0] <= s_tdata[31:0];
      ctr[1] <= s_tdata[63:32];
      ctr[2] <= s_tdata[95:64];
      scl[0] <= s_tdata[115:96];
      scl[1] <= s_tdata[135:116];
      scl[2] <= s_tdata[155:136];
      last_q <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      axis       <= '0;
      upper      <= 1'b0;
      miss       <= 1'b0;
      near_t     <= T_NEG_INF;
      far_t      <= T_POS_INF;
      cnt        <= '0;
      m_tvalid   <= 1'b0;
      best_dist  <= DIST_MAX;
      best_idx   <= '0;
      best_valid <= 1'b0;
      box_cnt    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            axis   <= '0;
            upper  <= 1'b0;
            miss   <= 1'b0;
            near_t <= T_NEG_INF;
            far_t  <= T_POS_INF;
            state  <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          if (dz) begin
            // origin must lie inside the slab, bounds inclusive
            if (!upper && !diff_neg && diff != '0) miss <= 1'b1;
            if (upper && diff_neg) miss <= 1'b1;
            upper <= !upper;
            if (upper) begin
              axis  <= axis + 2'd1;
              state <= (axis == 2'd2) ? ST_FIN : ST_SETUP;
            end
          end else begin
            num_sh <= {diff_mag, {(FRAC_BITS-1){1'b0}}};
            rem    <= '0;
            quo    <= '0;
            den    <= dmag;
            qneg   <= diff_neg ^ dval[DIR_W-1];
            cnt    <= CNTW'(NW);
            state  <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem    <= ge ? DIR_W'(trial - {1'b0, den}) : trial[DIR_W-1:0];
          quo    <= {quo[NW-2:0], ge};
          num_sh <= {num_sh[NW-2:0], 1'b0};
          cnt    <= cnt - 1'b1;
          if (cnt == CNTW'(1)) state <= ST_NEXT;
        end
        ST_NEXT: begin
          if (!upper) begin
            t_first <= tq;
          end else begin
            if (tmn > near_t) near_t <= tmn;
            if (tmx < far_t) far_t <= tmx;
          end
          upper <= !upper;
          if (upper) begin
            axis  <= axis + 2'd1;
            state <= (axis == 2'd2) ? ST_FIN : ST_SETUP;
          end else begin
            state <= ST_SETUP;
          end
        end
        ST_FIN: begin
          if (fin_fire) begin
            m_tlast  <= last_q;
            m_tdata  <= {7'b0,
                         upd ? box_cnt : best_idx,
                         best_valid | upd,
                         hit_len,
                         hit};
            if (last_q) begin
              best_dist  <= DIST_MAX;
              best_idx   <= '0;
              best_valid <= 1'b0;
              box_cnt    <= '0;
            end else begin
              if (upd) begin
                best_dist  <= hit_len;
                best_idx   <= box_cnt;
                best_valid <= 1'b1;
              end
              box_cnt <= ({23'b0, cnt_inc} >= 32'(MAX_BOXES)) ? '0 : cnt_inc[IDX_W-1:0];
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (fin_fire) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  `RBPC_ASSERT_NOW(a_div_den, state == ST_DIV, den != '0, "divider running on zero divisor")
  `RBPC_ASSERT_NOW(a_miss_dist, m_tvalid && !m_tdata[0], m_tdata[31:1] == '0, "miss with distance")
  `RBPC_ASSERT_NEXT(a_sweep_clear, fin_fire && last_q, !best_valid && box_cnt == '0, "tracker kept")

endmodule
